// File: rtl/mtep_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mtep_pkg
// Shared types, codes and helper functions for the MIDI track event parser.
// ----------------------------------------------------------------------------
package mtep_pkg;

    // One input item: a raw byte of the track chunk body.
    typedef struct packed {
        logic [7:0] track_byte;
        logic       last_of_track;
    } t_item;

    // One result item.
    typedef struct packed {
        logic [1:0]  kind;
        logic [31:0] delta_ticks;
        logic [7:0]  status;
        logic [7:0]  data_first;
        logic [7:0]  data_second;
        logic [7:0]  meta_code;
        logic [31:0] meta_length;
        logic [7:0]  meta_byte;
        logic        last_meta_byte;
        logic        end_of_track;
    } t_result;

    // Result kinds.
    localparam logic [1:0] KIND_CHANNEL   = 2'd0;
    localparam logic [1:0] KIND_META_HDR  = 2'd1;
    localparam logic [1:0] KIND_META_DATA = 2'd2;
    localparam logic [1:0] KIND_ERROR     = 2'd3;

    // Special status bytes.
    localparam logic [7:0] ST_SYSEX      = 8'hF0;
    localparam logic [7:0] ST_SYSEX_ESC  = 8'hF7;
    localparam logic [7:0] ST_COMMON_LO  = 8'hF1;
    localparam logic [7:0] ST_COMMON_HI  = 8'hF6;
    localparam logic [7:0] ST_META       = 8'hFF;
    localparam logic [3:0] HI_NOTE_OFF   = 4'h8;
    localparam logic [3:0] HI_NOTE_ON    = 4'h9;

    // Parser phases.
    typedef enum logic [2:0] {
        PH_DELTA,
        PH_EVTYPE,
        PH_MIDI,
        PH_META_TYPE,
        PH_META_LEN,
        PH_META_DATA,
        PH_SYSEX_LEN,
        PH_SYSEX_DATA
    } t_phase;

    // Handshake controls from the top level to the parser core.
    typedef struct packed {
        logic fire;
        logic cfg_we;
        logic cfg_data;
    } t_core_ctrl;

    // Number of data bytes that follow a channel status byte.
    function automatic logic [1:0] data_count(input logic [7:0] st);
        logic [1:0] cnt;
        case (st[7:4])
            4'h8, 4'h9, 4'hA, 4'hB, 4'hE: cnt = 2'd2;
            4'hC, 4'hD: cnt = 2'd1;
            default: cnt = 2'd0;
        endcase
        return cnt;
    endfunction

    // Shift seven more bits into a variable-length value, keeping 32 bits.
    function automatic logic [31:0] vlq_shift(input logic [31:0] acc,
                                              input logic [7:0] b);
        return {acc[24:0], b[6:0]};
    endfunction

endpackage

// File: rtl/midi_track_event_parser.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// midi_track_event_parser
// Parses a MIDI track chunk body, one byte per item, into channel, meta and
// error result items.
// ----------------------------------------------------------------------------
// Usage: feed the track body one byte per item and flag its final byte with
// last_of_track. Each byte is decoded between an input register and a result
// register, so the block sustains one item per clock when the consumer keeps
// i_ready high; each byte is held in the input register and its result in
// the result register. A stalled result only holds the input side once
// both registers are full. Bytes that finish no event give no result. The
// report_meta register is written through i_cfg_we / i_cfg_data and should
// only change while the block is idle.
module midi_track_event_parser (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_valid,
    output logic              o_ready,
    input  mtep_pkg::t_item   i_item,
    output logic              o_valid,
    input  logic              i_ready,
    output mtep_pkg::t_result o_result,
    input  logic              i_cfg_we,
    input  logic              i_cfg_data
);
    import mtep_pkg::*;

    logic       in_valid;
    t_item      in_item;
    logic       can_load;
    logic       fire;
    logic       emit;
    t_result    core_result;
    t_core_ctrl ctrl;

    // The held byte is decoded when the result register can take its result.
    assign fire          = in_valid && can_load;
    assign ctrl.fire     = fire;
    assign ctrl.cfg_we   = i_cfg_we;
    assign ctrl.cfg_data = i_cfg_data;

    mtep_in_reg u_in_reg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .o_ready (o_ready),
        .i_item  (i_item),
        .i_take  (fire),
        .o_valid (in_valid),
        .o_item  (in_item)
    );

    mtep_core u_core (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_ctrl   (ctrl),
        .i_item   (in_item),
        .o_emit   (emit),
        .o_result (core_result)
    );

    mtep_out_reg u_out_reg (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_load     (fire && emit),
        .i_result   (core_result),
        .o_can_load (can_load),
        .o_valid    (o_valid),
        .i_ready    (i_ready),
        .o_result   (o_result)
    );

`ifndef NO_ASSERTIONS
    // A held byte that is not decoded stays in the input register.
    a_in_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_valid && !fire |=> in_valid)
        else $error("input item lost before decode");

    // A decoded byte with a result always shows up at the output.
    a_emit_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        fire && emit |=> o_valid)
        else $error("result item dropped");

    // The input side only stalls while a byte waits for the result register.
    a_ready: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_ready |-> in_valid && o_valid && !i_ready)
        else $error("input stalled without cause");
`endif

endmodule

// File: rtl/mtep_in_reg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mtep_in_reg
// Input register: captures one item and holds it until the core takes it.
// ----------------------------------------------------------------------------
module mtep_in_reg (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_valid,
    output logic           o_ready,
    input  mtep_pkg::t_item i_item,
    input  logic           i_take,
    output logic           o_valid,
    output mtep_pkg::t_item o_item
);
    import mtep_pkg::*;

    logic  r_valid;
    t_item r_item;

    // The slot is free when empty or when its item leaves this cycle.
    assign o_ready = !r_valid || i_take;
    assign o_valid = r_valid;
    assign o_item  = r_item;

    // Valid flag.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
    end

    // Payload.
    always_ff @(posedge i_clk) begin
        if (o_ready && i_valid) begin
            r_item <= i_item;
        end
    end

endmodule

// File: rtl/mtep_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mtep_core
// Parser state and the single-pass decode of one track byte into at most
// one result item.
// ----------------------------------------------------------------------------
module mtep_core (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  mtep_pkg::t_core_ctrl i_ctrl,
    input  mtep_pkg::t_item     i_item,
    output logic                o_emit,
    output mtep_pkg::t_result   o_result
);
    import mtep_pkg::*;

    t_phase      r_phase, n_phase;
    logic [31:0] r_delta, n_delta;
    logic [31:0] r_length, n_length;
    logic [31:0] r_left, n_left;
    logic [7:0]  r_running, n_running;
    logic [7:0]  r_current, n_current;
    logic [7:0]  r_first, n_first;
    logic [7:0]  r_meta_code, n_meta_code;
    logic        r_error, n_error;
    logic        r_report_meta;

    // Next state and result for the byte in the input register.
    always_comb begin
        logic [7:0] b;
        logic       last;
        logic       more;
        logic       bad;
        logic       emit;
        logic [1:0] cnt;
        logic [7:0] st;
        t_result    res;

        b    = i_item.track_byte;
        last = i_item.last_of_track;
        more = 1'b0;
        bad  = 1'b0;
        emit = 1'b0;
        cnt  = 2'd0;
        st   = 8'd0;
        res  = '0;

        n_phase     = r_phase;
        n_delta     = r_delta;
        n_length    = r_length;
        n_left      = r_left;
        n_running   = r_running;
        n_current   = r_current;
        n_first     = r_first;
        n_meta_code = r_meta_code;
        n_error     = r_error;

        res.delta_ticks = r_delta;

        if (r_error) begin
            // Swallow bytes until the track ends.
            if (last) begin
                n_phase   = PH_DELTA;
                n_delta   = 32'd0;
                n_running = 8'd0;
                n_error   = 1'b0;
            end
        end else begin
            case (r_phase)
                PH_EVTYPE: begin
                    if (b == ST_SYSEX || b == ST_SYSEX_ESC) begin
                        n_running = 8'd0;
                        n_length  = 32'd0;
                        n_phase   = PH_SYSEX_LEN;
                        more      = 1'b1;
                    end else if (b >= ST_COMMON_LO && b <= ST_COMMON_HI) begin
                        n_running = 8'd0;
                    end else if (b == ST_META) begin
                        n_phase = PH_META_TYPE;
                        more    = 1'b1;
                    end else if (b[7]) begin
                        // Explicit channel status.
                        n_running = b;
                        n_current = b;
                        cnt = data_count(b);
                        if (cnt == 2'd0) begin
                            emit = 1'b1;
                            st   = b;
                        end else begin
                            n_left  = {30'd0, cnt};
                            n_phase = PH_MIDI;
                            more    = 1'b1;
                        end
                    end else begin
                        // Running status: this byte is the first data byte.
                        n_current = r_running;
                        cnt = data_count(r_running);
                        if (cnt == 2'd0) begin
                            bad = 1'b1;
                        end else if (cnt == 2'd1) begin
                            emit = 1'b1;
                            st   = r_running;
                            res.data_first = b;
                        end else begin
                            n_first = b;
                            n_left  = 32'd1;
                            n_phase = PH_MIDI;
                            more    = 1'b1;
                        end
                    end
                end
                PH_MIDI: begin
                    if (r_left >= 32'd2) begin
                        n_first = b;
                        n_left  = 32'd1;
                        more    = 1'b1;
                    end else if (data_count(r_current) == 2'd2) begin
                        emit = 1'b1;
                        st   = r_current;
                        res.data_first  = r_first;
                        res.data_second = b;
                    end else begin
                        emit = 1'b1;
                        st   = r_current;
                        res.data_first = b;
                    end
                end
                PH_META_TYPE: begin
                    n_meta_code = b;
                    n_length    = 32'd0;
                    n_phase     = PH_META_LEN;
                    more        = 1'b1;
                end
                PH_META_LEN: begin
                    n_length = vlq_shift(r_length, b);
                    if (b[7]) begin
                        more = 1'b1;
                    end else begin
                        emit = r_report_meta;
                        res.kind        = KIND_META_HDR;
                        res.meta_code   = r_meta_code;
                        res.meta_length = n_length;
                        if (n_length != 32'd0) begin
                            n_left  = n_length;
                            n_phase = PH_META_DATA;
                            more    = 1'b1;
                        end
                    end
                end
                PH_META_DATA: begin
                    emit = r_report_meta;
                    res.kind           = KIND_META_DATA;
                    res.meta_code      = r_meta_code;
                    res.meta_length    = r_length;
                    res.meta_byte      = b;
                    res.last_meta_byte = (r_left <= 32'd1);
                    if (r_left > 32'd1) begin
                        n_left = r_left - 32'd1;
                        more   = 1'b1;
                    end else begin
                        n_left = 32'd0;
                    end
                end
                PH_SYSEX_LEN: begin
                    n_length = vlq_shift(r_length, b);
                    if (b[7]) begin
                        more = 1'b1;
                    end else if (n_length != 32'd0) begin
                        n_left  = n_length;
                        n_phase = PH_SYSEX_DATA;
                        more    = 1'b1;
                    end
                end
                PH_SYSEX_DATA: begin
                    if (r_left > 32'd1) begin
                        n_left = r_left - 32'd1;
                        more   = 1'b1;
                    end else begin
                        n_left = 32'd0;
                    end
                end
                default: begin
                    // Delta time bytes.
                    n_delta = vlq_shift(r_delta, b);
                    n_phase = b[7] ? PH_DELTA : PH_EVTYPE;
                    more    = 1'b1;
                end
            endcase

            // Note-on with zero velocity becomes note-off.
            if (st[7:4] == HI_NOTE_ON && res.data_second == 8'd0) begin
                res.status = {HI_NOTE_OFF, st[3:0]};
            end else begin
                res.status = st;
            end

            if (more && last) begin
                bad = 1'b1;
            end

            if (bad) begin
                // Error result replaces anything this byte would have made.
                emit = 1'b1;
                res  = '0;
                res.kind         = KIND_ERROR;
                res.end_of_track = last;
                if (last) begin
                    n_phase   = PH_DELTA;
                    n_delta   = 32'd0;
                    n_running = 8'd0;
                    n_error   = 1'b0;
                end else begin
                    n_error = 1'b1;
                end
            end else begin
                res.end_of_track = last;
                if (!more) begin
                    // Event complete: start on the next delta time.
                    n_phase = PH_DELTA;
                    n_delta = 32'd0;
                    if (last) begin
                        n_running = 8'd0;
                        n_error   = 1'b0;
                    end
                end
            end
        end

        o_emit   = emit;
        o_result = res;
    end

    // Parser state, advanced once per consumed item.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase     <= PH_DELTA;
            r_delta     <= 32'd0;
            r_length    <= 32'd0;
            r_left      <= 32'd0;
            r_running   <= 8'd0;
            r_current   <= 8'd0;
            r_first     <= 8'd0;
            r_meta_code <= 8'd0;
            r_error     <= 1'b0;
        end else if (i_ctrl.fire) begin
            r_phase     <= n_phase;
            r_delta     <= n_delta;
            r_length    <= n_length;
            r_left      <= n_left;
            r_running   <= n_running;
            r_current   <= n_current;
            r_first     <= n_first;
            r_meta_code <= n_meta_code;
            r_error     <= n_error;
        end
    end

    // Meta reporting register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_report_meta <= 1'b1;
        end else if (i_ctrl.cfg_we) begin
            r_report_meta <= i_ctrl.cfg_data;
        end
    end

endmodule

// File: rtl/mtep_out_reg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mtep_out_reg
// Result register: holds one result item until the consumer takes it.
// ----------------------------------------------------------------------------
module mtep_out_reg (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_load,
    input  mtep_pkg::t_result i_result,
    output logic              o_can_load,
    output logic              o_valid,
    input  logic              i_ready,
    output mtep_pkg::t_result o_result
);
    import mtep_pkg::*;

    logic    r_valid;
    t_result r_result;

    // A new result may enter when the slot is empty or being drained.
    assign o_can_load = !r_valid || i_ready;
    assign o_valid    = r_valid;
    assign o_result   = r_result;

    // Valid flag.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_can_load) begin
            r_valid <= i_load;
        end
    end

    // Payload.
    always_ff @(posedge i_clk) begin
        if (o_can_load && i_load) begin
            r_result <= i_result;
        end
    end

endmodule

// File: tb/midi_track_event_parser_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// midi_track_event_parser_tb
// Self-checking bench for the MIDI track event parser. Track bodies are built
// from random, mostly well-formed events, including truncated tracks and
// noise. Every accepted byte is decoded by a predictor inside a small
// scoreboard, and every result item is compared field by field in order.
// ----------------------------------------------------------------------------
module midi_track_event_parser_tb;
    import mtep_pkg::*;

    localparam int          CYCLE_LIMIT       = 400000;
    localparam int          SETTLE_CYCLES     = 6;
    localparam int unsigned PHASE_BYTES       = 570;
    localparam logic [7:0]  META_END_OF_TRACK = 8'h2F;

    // Scoreboard: decodes accepted bytes into expected results and checks them.
    class midi_event_scoreboard;
        bit          show_meta;
        t_phase      ph;
        logic [31:0] delta_acc;
        logic [31:0] len_acc;
        logic [31:0] remaining;
        logic [7:0]  run_st;
        logic [7:0]  cur_st;
        logic [7:0]  held_data;
        logic [7:0]  meta_kind;
        bit          err_latched;
        t_result     pending_events[$];
        int          failures;
        int          checked;
        int          meta_seen;
        int          errors_seen;

        function new();
            show_meta = 1'b1;
            len_acc = '0;
            remaining = '0;
            cur_st = '0;
            held_data = '0;
            meta_kind = '0;
            failures = 0;
            checked = 0;
            meta_seen = 0;
            errors_seen = 0;
            end_track();
        endfunction

        function void end_track();
            ph = PH_DELTA;
            delta_acc = '0;
            run_st = '0;
            err_latched = 1'b0;
        endfunction

        // Number of data bytes after a channel status byte.
        function int unsigned data_bytes(logic [7:0] st);
            case (st[7:4])
                4'h8, 4'h9, 4'hA, 4'hB, 4'hE: return 2;
                4'hC, 4'hD: return 1;
                default: return 0;
            endcase
        endfunction

        function t_result channel_event(logic [7:0] st, logic [7:0] d1, logic [7:0] d2);
            t_result r;
            r = '0;
            // A note-on with zero velocity is reported as a note-off.
            if (st[7:4] == HI_NOTE_ON && d2 == 8'h00) begin
                st = {HI_NOTE_OFF, st[3:0]};
            end
            r.kind = KIND_CHANNEL;
            r.delta_ticks = delta_acc;
            r.status = st;
            r.data_first = d1;
            r.data_second = d2;
            return r;
        endfunction

        function bit meta_event(logic [1:0] k, logic [7:0] b, bit lastb, output t_result r);
            r = '0;
            if (!show_meta) begin
                return 1'b0;
            end
            r.kind = k;
            r.delta_ticks = delta_acc;
            r.meta_code = meta_kind;
            r.meta_length = len_acc;
            r.meta_byte = b;
            r.last_meta_byte = lastb;
            return 1'b1;
        endfunction

        // Advance the parser state by one accepted byte.
        function void accept_byte(t_item it);
            logic [7:0] b;
            bit         last;
            bit         more;
            bit         bad;
            bit         have;
            t_result    r;
            b = it.track_byte;
            last = it.last_of_track;
            more = 1'b0;
            bad = 1'b0;
            have = 1'b0;
            r = '0;

            // After an error, bytes are swallowed until the track ends.
            if (err_latched) begin
                if (last) begin
                    end_track();
                end
                return;
            end

            case (ph)
                PH_EVTYPE: begin
                    if (b == ST_SYSEX || b == ST_SYSEX_ESC) begin
                        run_st = '0;
                        len_acc = '0;
                        ph = PH_SYSEX_LEN;
                        more = 1'b1;
                    end else if (b >= ST_COMMON_LO && b <= ST_COMMON_HI) begin
                        run_st = '0;
                    end else if (b == ST_META) begin
                        ph = PH_META_TYPE;
                        more = 1'b1;
                    end else if (b[7]) begin
                        run_st = b;
                        cur_st = b;
                        if (data_bytes(b) == 0) begin
                            r = channel_event(b, 8'h00, 8'h00);
                            have = 1'b1;
                        end else begin
                            remaining = data_bytes(b);
                            ph = PH_MIDI;
                            more = 1'b1;
                        end
                    end else begin
                        // Running status: the byte is the first data byte.
                        cur_st = run_st;
                        case (data_bytes(cur_st))
                            0: bad = 1'b1;
                            1: begin
                                r = channel_event(cur_st, b, 8'h00);
                                have = 1'b1;
                            end
                            default: begin
                                held_data = b;
                                remaining = 1;
                                ph = PH_MIDI;
                                more = 1'b1;
                            end
                        endcase
                    end
                end
                PH_MIDI: begin
                    if (remaining >= 2) begin
                        held_data = b;
                        remaining = 1;
                        more = 1'b1;
                    end else if (data_bytes(cur_st) == 2) begin
                        r = channel_event(cur_st, held_data, b);
                        have = 1'b1;
                    end else begin
                        r = channel_event(cur_st, b, 8'h00);
                        have = 1'b1;
                    end
                end
                PH_META_TYPE: begin
                    meta_kind = b;
                    len_acc = '0;
                    ph = PH_META_LEN;
                    more = 1'b1;
                end
                PH_META_LEN: begin
                    len_acc = {len_acc[24:0], b[6:0]};
                    if (b[7]) begin
                        more = 1'b1;
                    end else begin
                        have = meta_event(KIND_META_HDR, 8'h00, 1'b0, r);
                        if (len_acc != 0) begin
                            remaining = len_acc;
                            ph = PH_META_DATA;
                            more = 1'b1;
                        end
                    end
                end
                PH_META_DATA: begin
                    have = meta_event(KIND_META_DATA, b, remaining <= 1, r);
                    if (remaining > 1) begin
                        remaining = remaining - 1;
                        more = 1'b1;
                    end else begin
                        remaining = '0;
                    end
                end
                PH_SYSEX_LEN: begin
                    len_acc = {len_acc[24:0], b[6:0]};
                    if (b[7]) begin
                        more = 1'b1;
                    end else if (len_acc != 0) begin
                        remaining = len_acc;
                        ph = PH_SYSEX_DATA;
                        more = 1'b1;
                    end
                end
                PH_SYSEX_DATA: begin
                    if (remaining > 1) begin
                        remaining = remaining - 1;
                        more = 1'b1;
                    end else begin
                        remaining = '0;
                    end
                end
                default: begin
                    delta_acc = {delta_acc[24:0], b[6:0]};
                    ph = b[7] ? PH_DELTA : PH_EVTYPE;
                    more = 1'b1;
                end
            endcase

            // A track that ends inside an event gives one error instead.
            if (more && last) begin
                bad = 1'b1;
            end
            if (bad) begin
                r = '0;
                r.kind = KIND_ERROR;
                r.end_of_track = last;
                pending_events.push_back(r);
                if (last) begin
                    end_track();
                end else begin
                    err_latched = 1'b1;
                end
                return;
            end

            if (have) begin
                r.end_of_track = last;
                pending_events.push_back(r);
            end
            if (!more) begin
                ph = PH_DELTA;
                delta_acc = '0;
                if (last) begin
                    end_track();
                end
            end
        endfunction

        function void compare_field(string name, logic [31:0] want, logic [31:0] got);
            if (want !== got) begin
                $error("%s mismatch: expected 0x%0h, actual 0x%0h", name, want, got);
                failures++;
            end
        endfunction

        // Compare one result item with the oldest expectation.
        function void check_event(t_result got);
            t_result want;
            if (pending_events.size() == 0) begin
                $error("result item with nothing expected, kind %0d", got.kind);
                failures++;
                return;
            end
            want = pending_events.pop_front();
            checked++;
            if (want.kind == KIND_ERROR) begin
                errors_seen++;
            end else if (want.kind != KIND_CHANNEL) begin
                meta_seen++;
            end
            compare_field("kind", want.kind, got.kind);
            compare_field("delta_ticks", want.delta_ticks, got.delta_ticks);
            compare_field("status", want.status, got.status);
            compare_field("data_first", want.data_first, got.data_first);
            compare_field("data_second", want.data_second, got.data_second);
            compare_field("meta_code", want.meta_code, got.meta_code);
            compare_field("meta_length", want.meta_length, got.meta_length);
            compare_field("meta_byte", want.meta_byte, got.meta_byte);
            compare_field("last_meta_byte", want.last_meta_byte, got.last_meta_byte);
            compare_field("end_of_track", want.end_of_track, got.end_of_track);
        endfunction
    endclass

    logic        i_clk;
    logic        i_rst_n;
    logic        i_valid;
    logic        o_ready;
    t_item       i_item;
    logic        o_valid;
    logic        i_ready;
    t_result     o_result;
    logic        i_cfg_we;
    logic        i_cfg_data;

    int unsigned gap_pct;
    int unsigned stall_pct;
    int          cycle_count;
    int unsigned bytes_sent;
    int unsigned tracks_sent;
    logic [7:0]  track_bytes[$];
    logic [7:0]  gen_running;
    midi_event_scoreboard sb;

    midi_track_event_parser uut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_valid    (i_valid),
        .o_ready    (o_ready),
        .i_item     (i_item),
        .o_valid    (o_valid),
        .i_ready    (i_ready),
        .o_result   (o_result),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_data (i_cfg_data)
    );

    // 20 ns clock.
    always begin
        i_clk = 1'b0;
        #10;
        i_clk = 1'b1;
        #10;
    end

    // Guard against a hung handshake.
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("CHECK FAILED");
            $finish;
        end
    end

    // Receiver stalls at random.
    always @(negedge i_clk) begin
        i_ready <= ($urandom_range(99) >= stall_pct);
    end

    // Check every result item as it is taken.
    always @(posedge i_clk) begin
        if (i_rst_n && o_valid && i_ready) begin
            sb.check_event(o_result);
        end
    end

    // Offer one byte, with random gaps, and hold it until it is taken.
    task automatic send_item(logic [7:0] b, bit last);
        t_item it;
        it.track_byte = b;
        it.last_of_track = last;
        while ($urandom_range(99) < gap_pct) begin
            i_valid <= 1'b0;
            @(negedge i_clk);
        end
        i_valid <= 1'b1;
        i_item <= it;
        do @(posedge i_clk); while (!o_ready);
        sb.accept_byte(it);
        bytes_sent++;
        @(negedge i_clk);
    endtask

    task automatic send_track();
        foreach (track_bytes[i]) begin
            send_item(track_bytes[i], i == track_bytes.size() - 1);
        end
        tracks_sent++;
    endtask

    // Hold the input side until every expected result has come out.
    task automatic settle();
        i_valid <= 1'b0;
        while (sb.pending_events.size() != 0) begin
            @(negedge i_clk);
        end
        repeat (SETTLE_CYCLES) @(negedge i_clk);
    endtask

    task automatic write_report_meta(bit v);
        i_cfg_we <= 1'b1;
        i_cfg_data <= v;
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
        sb.show_meta = v;
    endtask

    // Data byte: mostly in range, sometimes with bit 7 set.
    function automatic logic [7:0] rand_data();
        if ($urandom_range(9) == 0) begin
            return 8'($urandom_range(128, 255));
        end
        return 8'($urandom_range(0, 127));
    endfunction

    // Delta time: usually one byte, sometimes long enough to overflow 32 bits.
    task automatic add_delta();
        int unsigned r;
        int unsigned nb;
        r = $urandom_range(99);
        nb = (r < 60) ? 1 : (r < 92) ? $urandom_range(2, 4) : $urandom_range(5, 6);
        repeat (nb - 1) track_bytes.push_back(8'($urandom_range(128, 255)));
        track_bytes.push_back(8'($urandom_range(0, 127)));
    endtask

    // Length field, now and then padded with a leading zero group.
    task automatic add_length(logic [13:0] v);
        if (v > 127) begin
            track_bytes.push_back({1'b1, v[13:7]});
        end else if ($urandom_range(7) == 0) begin
            track_bytes.push_back(8'h80);
        end
        track_bytes.push_back({1'b0, v[6:0]});
    endtask

    function automatic int unsigned pick_len();
        if ($urandom_range(19) == 0) begin
            return $urandom_range(128, 160);
        end
        return $urandom_range(0, 5);
    endfunction

    task automatic add_channel(logic [7:0] st, bit with_status);
        int unsigned n;
        n = sb.data_bytes(st);
        if (with_status) begin
            track_bytes.push_back(st);
        end
        if (n == 2) begin
            track_bytes.push_back(rand_data());
            if (st[7:4] == HI_NOTE_ON && $urandom_range(3) == 0) begin
                track_bytes.push_back(8'h00);
            end else begin
                track_bytes.push_back(rand_data());
            end
        end else if (n == 1) begin
            track_bytes.push_back(rand_data());
        end
    endtask

    // One event with its delta time; the mix leans toward well-formed events.
    task automatic add_event();
        logic [7:0]  st;
        int unsigned r;
        int unsigned len;
        r = $urandom_range(99);
        add_delta();
        if (r < 55) begin
            if (r >= 35 && gen_running != 8'h00) begin
                add_channel(gen_running, 1'b0);
            end else begin
                st = {4'($urandom_range(8, 14)), 4'($urandom_range(0, 15))};
                add_channel(st, 1'b1);
                gen_running = st;
            end
        end else if (r < 60) begin
            track_bytes.push_back(8'($urandom_range(8'hF8, 8'hFE)));
            gen_running = 8'h00;
        end else if (r < 75) begin
            track_bytes.push_back(ST_META);
            track_bytes.push_back(8'($urandom()));
            len = pick_len();
            add_length(14'(len));
            repeat (len) track_bytes.push_back(8'($urandom()));
        end else if (r < 83) begin
            track_bytes.push_back($urandom_range(1) ? ST_SYSEX : ST_SYSEX_ESC);
            gen_running = 8'h00;
            len = pick_len();
            add_length(14'(len));
            repeat (len) track_bytes.push_back(8'($urandom()));
        end else if (r < 88) begin
            track_bytes.push_back(8'($urandom_range(ST_COMMON_LO, ST_COMMON_HI)));
            gen_running = 8'h00;
        end else begin
            repeat ($urandom_range(1, 3)) track_bytes.push_back(8'($urandom()));
            gen_running = 8'h00;
        end
    endtask

    // A track ends cleanly, is cut off mid-event, or just stops.
    task automatic build_track();
        int unsigned r;
        int unsigned cut;
        track_bytes.delete();
        gen_running = 8'h00;
        repeat ($urandom_range(1, 10)) add_event();
        r = $urandom_range(99);
        if (r < 60) begin
            track_bytes.push_back(8'h00);
            track_bytes.push_back(ST_META);
            track_bytes.push_back(META_END_OF_TRACK);
            track_bytes.push_back(8'h00);
        end else if (r < 80 && track_bytes.size() > 1) begin
            cut = $urandom_range(1, track_bytes.size() - 1);
            while (track_bytes.size() > cut) begin
                void'(track_bytes.pop_back());
            end
        end
    endtask

    // One idle pattern; halfway through, drain and flip the meta setting.
    task automatic run_phase(int unsigned gap, int unsigned stall, bit meta_a, bit meta_b);
        int unsigned start;
        bit          paused;
        settle();
        write_report_meta(meta_a);
        gap_pct = gap;
        stall_pct = stall;
        start = bytes_sent;
        paused = 1'b0;
        while (bytes_sent - start < PHASE_BYTES) begin
            build_track();
            send_track();
            if (!paused && bytes_sent - start >= PHASE_BYTES / 2) begin
                settle();
                write_report_meta(meta_b);
                paused = 1'b1;
            end
        end
    endtask

    initial begin
        i_rst_n = 1'b0;
        i_valid = 1'b0;
        i_item = '0;
        i_ready = 1'b0;
        i_cfg_we = 1'b0;
        i_cfg_data = 1'b0;
        gap_pct = 0;
        stall_pct = 0;
        cycle_count = 0;
        bytes_sent = 0;
        tracks_sent = 0;
        sb = new();

        repeat (4) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Note-on, running-status note-off, a system common byte that drops
        // running status, then data with no status, swallowed to track end.
        track_bytes = '{8'h00, 8'h90, 8'h3C, 8'h64,
                        8'h00, 8'h3C, 8'h00,
                        8'h00, 8'hF3,
                        8'h00, 8'h40,
                        8'hFF};
        send_track();
        // Overflowing delta with a data byte that has bit 7 set, a one-byte
        // meta event, and a track that ends inside a sysex length.
        track_bytes = '{8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'h7F, 8'hC5, 8'hFF,
                        8'h00, 8'hFF, 8'h01, 8'h01, 8'h80,
                        8'h00, 8'hF7, 8'h81};
        send_track();

        run_phase(35, 50, 1'b0, 1'b1);
        run_phase(50, 35, 1'b1, 1'b0);
        run_phase(0, 0, 1'b0, 1'b1);
        settle();

        $display("Sent %0d bytes in %0d tracks under three idle patterns, meta reporting on and off.",
                 bytes_sent, tracks_sent);
        $display("Checked %0d result items: %0d meta, %0d error.",
                 sb.checked, sb.meta_seen, sb.errors_seen);
        if (sb.failures == 0 && sb.pending_events.size() == 0) begin
            $display("CHECK OK");
        end else begin
            $display("CHECK FAILED");
        end
        $finish;
    end

endmodule
